[hw/rtl/pair_distance_consistency_score_macros.svh]
// Assertion macros shared by the pair distance consistency score RTL.
// Expects clk and rst in the scope of each use.
`ifndef PAIR_DISTANCE_CONSISTENCY_SCORE_MACROS_SVH
`define PAIR_DISTANCE_CONSISTENCY_SCORE_MACROS_SVH

// same-cycle implication
`define PDCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pdcs_pkg.sv]
// Shared constants, register codes and stage structs for the
// pair distance consistency score pipeline. No dependencies.
package pdcs_pkg;

  localparam int COORD_W         = 32;
  localparam int NUM_COORDS      = 12;
  localparam int IN_W            = COORD_W * NUM_COORDS;
  localparam int SCORE_FRAC_BITS = 16;
  localparam int SCORE_W         = SCORE_FRAC_BITS + 1;
  localparam int OUT_W           = ((SCORE_W + 7) / 8) * 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  localparam int SQRT_STEPS = 34;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;

  localparam int CUTOFF_BITS  = 5;
  localparam int FRAC_W       = 32;
  localparam int SERIES_TERMS = 14;
  localparam int MAGIC_SHIFT  = 36;
  localparam logic [30:0] EXP_M1_Q32 = 31'd1580030169;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DIST = 3'd0,
    REG_GATE_EPS = 3'd1,
    REG_SIGMA    = 3'd2,
    REG_GRAVITY  = 3'd3,
    REG_DIMS     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        v;
    logic        kill;
    logic [63:0] num;
    logic [63:0] den;
  } gauss_in_t;

  typedef struct packed {
    logic               v;
    logic [SCORE_W-1:0] score;
  } gauss_out_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] d);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

endpackage

[hw/rtl/pdcs_isqrt.sv]
// Fully pipelined floor square root, one result bit per stage.
// Depends on pdcs_pkg.
module pdcs_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [pdcs_pkg::RAD_W-1:0]  rad,
  output logic [pdcs_pkg::ROOT_W-1:0] root
);
  import pdcs_pkg::*;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [37:0]       rem;
  } sq_t;

  sq_t st [SQRT_STEPS+1];

  assign st[0] = '{rad: rad, root: '0, rem: '0};

  for (genvar i = 1; i <= SQRT_STEPS; i++) begin : g_step
    sq_t         nx;
    logic [37:0] remsh;
    logic [37:0] trial;

    always_comb begin
      remsh  = {st[i-1].rem[35:0], st[i-1].rad[RAD_W-1 -: 2]};
      trial  = 38'({st[i-1].root, 2'b01});
      nx.rad = {st[i-1].rad[RAD_W-3:0], 2'b00};
      if (remsh >= trial) begin
        nx.rem  = remsh - trial;
        nx.root = {st[i-1].root[ROOT_W-2:0], 1'b1};
      end else begin
        nx.rem  = remsh;
        nx.root = {st[i-1].root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) st[i] <= nx;
    end
  end

  assign root = st[SQRT_STEPS].root;

endmodule

[hw/rtl/pdcs_gauss.sv]
// Pipelined exp(-num/den): long division to quotient and 32-bit fraction,
// Taylor series for the fraction, exp(-1) steps for the quotient, rounding.
// Depends on pdcs_pkg.
module pdcs_gauss (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  pdcs_pkg::gauss_in_t    din,
  output pdcs_pkg::gauss_out_t   dout
);
  import pdcs_pkg::*;

  localparam int DIV_STAGES = CUTOFF_BITS + FRAC_W;
  localparam int SER_STAGES = 2 * SERIES_TERMS;
  localparam int POW_STAGES = (1 << CUTOFF_BITS) - 1;

  typedef struct packed {
    logic                   v;
    logic                   kill;
    logic [CUTOFF_BITS-1:0] q;
    logic [FRAC_W-1:0]      f;
    logic [63:0]            rem;
    logic [63:0]            den;
  } div_t;

  typedef struct packed {
    logic                   v;
    logic                   kill;
    logic [CUTOFF_BITS-1:0] q;
    logic [FRAC_W-1:0]      f;
    logic [33:0]            s;
    logic [68:0]            acc;
  } ser_t;

  typedef struct packed {
    logic                   v;
    logic                   kill;
    logic [CUTOFF_BITS-1:0] q;
    logic [32:0]            s;
  } pow_t;

  div_t dv [DIV_STAGES+1];
  ser_t sr [SER_STAGES+1];
  pow_t pw [POW_STAGES+1];

  assign dv[0] = '{v: din.v, kill: din.kill, q: '0, f: '0, rem: din.num, den: din.den};

  // integer quotient bits, MSB first; the first step also flags q >= 32
  for (genvar i = 1; i <= CUTOFF_BITS; i++) begin : g_int
    localparam int SH = CUTOFF_BITS - i;
    div_t        nx;
    logic [68:0] dsh;
    logic [68:0] rx;

    always_comb begin
      nx  = dv[i-1];
      dsh = 69'(dv[i-1].den) << SH;
      rx  = 69'(dv[i-1].rem);
      if (i == 1) nx.kill = dv[i-1].kill | (rx >= (69'(dv[i-1].den) << CUTOFF_BITS));
      if (rx >= dsh) begin
        nx.rem   = 64'(rx - dsh);
        nx.q[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i].v <= 1'b0;
      end else if (en) begin
        dv[i] <= nx;
      end
    end
  end

  // fraction bits
  for (genvar i = CUTOFF_BITS + 1; i <= DIV_STAGES; i++) begin : g_frac
    div_t        nx;
    logic [64:0] r2;
    logic [64:0] d65;

    always_comb begin
      nx  = dv[i-1];
      r2  = {dv[i-1].rem, 1'b0};
      d65 = {1'b0, dv[i-1].den};
      nx.f = {dv[i-1].f[FRAC_W-2:0], r2 >= d65};
      nx.rem = (r2 >= d65) ? 64'(r2 - d65) : r2[63:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i].v <= 1'b0;
      end else if (en) begin
        dv[i] <= nx;
      end
    end
  end

  // term 0 is 1.0, parked in acc so the first term step adds it in
  assign sr[0] = '{v: dv[DIV_STAGES].v, kill: dv[DIV_STAGES].kill, q: dv[DIV_STAGES].q,
                   f: dv[DIV_STAGES].f, s: '0, acc: 69'(1) << 68};

  for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
    localparam int K = k;
    localparam bit SUB_PREV = ((K - 1) % 2) == 1;
    localparam logic [36:0] MAGIC =
      37'(((64'd1 << MAGIC_SHIFT) + 64'(K) - 64'd1) / 64'(K));
    ser_t        nxa;
    ser_t        nxb;
    logic [32:0] term;
    logic [64:0] prod;

    // step A: fold in the previous term, multiply it by f
    always_comb begin
      nxa      = sr[2*k-2];
      term     = sr[2*k-2].acc[68:36];
      nxa.s    = SUB_PREV ? sr[2*k-2].s - 34'(term) : sr[2*k-2].s + 34'(term);
      prod     = 65'(term) * 65'(sr[2*k-2].f);
      nxa.acc  = 69'(prod);
    end

    // step B: floor divide by k through a reciprocal multiply
    always_comb begin
      nxb     = sr[2*k-1];
      nxb.acc = 69'(sr[2*k-1].acc[63:32]) * 69'(MAGIC);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sr[2*k-1].v <= 1'b0;
        sr[2*k].v   <= 1'b0;
      end else if (en) begin
        sr[2*k-1] <= nxa;
        sr[2*k]   <= nxb;
      end
    end
  end

  localparam bit SUB_LAST = (SERIES_TERMS % 2) == 1;
  logic [32:0] term_last;
  logic [33:0] s_last;

  always_comb begin
    term_last = sr[SER_STAGES].acc[68:36];
    s_last    = SUB_LAST ? sr[SER_STAGES].s - 34'(term_last)
                         : sr[SER_STAGES].s + 34'(term_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pw[0].v <= 1'b0;
    end else if (en) begin
      pw[0] <= '{v: sr[SER_STAGES].v, kill: sr[SER_STAGES].kill, q: sr[SER_STAGES].q,
                 s: s_last[32:0]};
    end
  end

  // one exp(-1) product per stage, applied while the stage index is below q
  for (genvar j = 0; j < POW_STAGES; j++) begin : g_pow
    pow_t        nx;
    logic [65:0] prod;

    always_comb begin
      nx   = pw[j];
      prod = 66'(pw[j].s) * 66'(EXP_M1_Q32);
      if (pw[j].q > CUTOFF_BITS'(j)) nx.s = 33'(prod >> 32);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pw[j+1].v <= 1'b0;
      end else if (en) begin
        pw[j+1] <= nx;
      end
    end
  end

  logic [33:0] rnd;
  assign rnd = 34'(pw[POW_STAGES].s) + (34'(1) << (31 - SCORE_FRAC_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.v <= 1'b0;
    end else if (en) begin
      dout.v     <= pw[POW_STAGES].v;
      dout.score <= pw[POW_STAGES].kill ? '0 : SCORE_W'(rnd >> (32 - SCORE_FRAC_BITS));
    end
  end

endmodule

[hw/rtl/pair_distance_consistency_score.sv]
// Throughput: one beat per cycle; every stage advances together and the
// whole pipe holds while the output register waits on m_axis_tready.
// Reset (rst, synchronous): empties the pipe, registers return to defaults.
// Depends on pdcs_pkg, pdcs_isqrt, pdcs_gauss and the assertion macros.
`include "pair_distance_consistency_score_macros.svh"

module pair_distance_consistency_score (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // a_i_x, a_i_y, a_i_z, a_j_x, a_j_y, a_j_z, b_i_x .. b_j_z (32 bits each)
  input  logic [pdcs_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // score [16:0], zero padded
  output logic [pdcs_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pdcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pdcs_pkg::*;

  localparam logic [SCORE_W-1:0] ONE = SCORE_W'(1) << SCORE_FRAC_BITS;

  typedef struct packed {
    logic        v;
    logic [33:0] czm;
  } side_t;

  logic adv;
  gauss_out_t gout;

  assign adv           = !gout.v || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = gout.v;
  assign m_axis_tdata  = OUT_W'(gout.score);
  assign cfg_ready     = 1'b1;

  // ---------------- configuration
  logic [30:0] min_dist;
  logic [30:0] gate_eps;
  logic [30:0] sigma;
  logic        gravity;
  logic [1:0]  dims;
  logic [61:0] eps_sq;
  logic [61:0] sig_sq;
  logic [30:0] sig_eff;
  logic        dims3;

  assign sig_eff = (sigma == '0) ? 31'd1 : sigma;
  assign dims3   = dims != 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist <= '0;
      gate_eps <= 31'd65536;
      sigma    <= 31'd65536;
      gravity  <= 1'b0;
      dims     <= 2'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MIN_DIST: min_dist <= cfg_data[30:0];
        REG_GATE_EPS: gate_eps <= cfg_data[30:0];
        REG_SIGMA:    sigma    <= cfg_data[30:0];
        REG_GRAVITY:  gravity  <= cfg_data[0];
        REG_DIMS:     dims     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // squares of the register values, settled long before an item needs them
  always_ff @(posedge clk) begin
    eps_sq <= 62'(gate_eps) * 62'(gate_eps);
    sig_sq <= 62'(sig_eff) * 62'(sig_eff);
  end

  // ---------------- stage 1: coordinate differences
  logic [COORD_W-1:0]  crd [NUM_COORDS];
  logic signed [32:0]  da_c [3];
  logic signed [32:0]  db_c [3];
  logic signed [33:0]  czd_c;
  logic signed [32:0]  da [3];
  logic signed [32:0]  db [3];
  logic signed [33:0]  czd;
  logic                v1;

  always_comb begin
    for (int n = 0; n < NUM_COORDS; n++) crd[n] = s_axis_tdata[COORD_W*n +: COORD_W];
    for (int k = 0; k < 3; k++) begin
      da_c[k] = $signed({crd[k][31], crd[k]}) - $signed({crd[3+k][31], crd[3+k]});
      db_c[k] = $signed({crd[6+k][31], crd[6+k]}) - $signed({crd[9+k][31], crd[9+k]});
    end
    czd_c = $signed({da_c[2][32], da_c[2]}) - $signed({db_c[2][32], db_c[2]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1  <= s_axis_tvalid;
      da  <= da_c;
      db  <= db_c;
      czd <= czd_c;
    end
  end

  // ---------------- stage 2: squares
  logic [32:0] ma [3];
  logic [32:0] mb [3];
  logic [64:0] sqa [3];
  logic [64:0] sqb [3];
  logic [33:0] czm2;
  logic        v2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ma[k] = mag33(da[k]);
      mb[k] = mag33(db[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      for (int k = 0; k < 3; k++) begin
        sqa[k] <= 65'(ma[k]) * 65'(ma[k]);
        sqb[k] <= 65'(mb[k]) * 65'(mb[k]);
      end
      czm2 <= czd[33] ? 34'(-czd) : 34'(czd);
    end
  end

  // ---------------- stage 3: radicands; 0/1 use dims, 2/3 are x,y only
  logic [RAD_W-1:0]  rad [4];
  logic [RAD_W-1:0]  axy;
  logic [RAD_W-1:0]  bxy;
  logic [ROOT_W-1:0] root [4];
  side_t             sd [SQRT_STEPS+1];

  assign axy = RAD_W'(sqa[0]) + RAD_W'(sqa[1]);
  assign bxy = RAD_W'(sqb[0]) + RAD_W'(sqb[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= SQRT_STEPS; i++) sd[i].v <= 1'b0;
    end else if (adv) begin
      rad[0] <= axy + (dims3 ? RAD_W'(sqa[2]) : '0);
      rad[1] <= bxy + (dims3 ? RAD_W'(sqb[2]) : '0);
      rad[2] <= axy;
      rad[3] <= bxy;
      sd[0]  <= '{v: v2, czm: czm2};
      for (int i = 1; i <= SQRT_STEPS; i++) sd[i] <= sd[i-1];
    end
  end

  for (genvar u = 0; u < 4; u++) begin : g_sqrt
    pdcs_isqrt u_isqrt (
      .clk  (clk),
      .en   (adv),
      .rad  (rad[u]),
      .root (root[u])
    );
  end

  // ---------------- stage 4: distance rule and gates
  logic [ROOT_W-1:0] c_std;
  logic [ROOT_W-1:0] c_xy;
  logic              kill_md;
  logic              kill_gate;
  logic              v4;
  logic              kill4;
  logic [30:0]       cm4;
  logic [30:0]       cz4;

  always_comb begin
    c_std   = (root[0] > root[1]) ? root[0] - root[1] : root[1] - root[0];
    c_xy    = (root[2] > root[3]) ? root[2] - root[3] : root[3] - root[2];
    kill_md = (min_dist != '0) &&
              ((root[0] < ROOT_W'(min_dist)) || (root[1] < ROOT_W'(min_dist)));
    if (gravity) begin
      kill_gate = (c_xy > ROOT_W'(gate_eps)) || (sd[SQRT_STEPS].czm > 34'(gate_eps));
    end else begin
      kill_gate = c_std > ROOT_W'(gate_eps);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4    <= sd[SQRT_STEPS].v;
      kill4 <= kill_md || kill_gate;
      cm4   <= gravity ? c_xy[30:0] : c_std[30:0];
      cz4   <= sd[SQRT_STEPS].czm[30:0];
    end
  end

  // ---------------- stage 5: squared inconsistencies (below 2^31 once gated)
  logic        v5;
  logic        kill5;
  logic [61:0] p_c;
  logic [61:0] p_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5    <= v4;
      kill5 <= kill4;
      p_c   <= 62'(cm4) * 62'(cm4);
      p_z   <= 62'(cz4) * 62'(cz4);
    end
  end

  // ---------------- stage 6: exponent numerator and denominator
  logic [63:0] g3xy;
  logic [63:0] g3z;
  logic        kill_split;
  gauss_in_t   gin;

  always_comb begin
    g3xy       = 64'({p_c, 1'b0}) + 64'(p_c);
    g3z        = 64'({p_z, 1'b0}) + 64'(p_z);
    kill_split = (g3xy > 64'({eps_sq, 1'b0})) || (g3z > 64'(eps_sq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gin.v <= 1'b0;
    end else if (adv) begin
      gin.v <= v5;
      if (gravity) begin
        gin.kill <= kill5 || kill_split;
        gin.num  <= g3xy + {g3z[62:0], 1'b0};
        gin.den  <= {sig_sq, 2'b00};
      end else begin
        gin.kill <= kill5;
        gin.num  <= 64'(p_c);
        gin.den  <= {1'b0, sig_sq, 1'b0};
      end
    end
  end

  pdcs_gauss u_gauss (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .din  (gin),
    .dout (gout)
  );

  // ---------------- checks
  `PDCS_ASSERT_NOW(a_score_range, m_axis_tvalid, gout.score <= ONE, "score above 1.0")
  `PDCS_ASSERT_NOW(a_stall_holds_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
                   "input taken while output stalled")
  `PDCS_ASSERT_NEXT(a_beat_enters, s_axis_tvalid && s_axis_tready, v1,
                    "accepted beat missing from stage one")
  `PDCS_ASSERT_NEXT(a_stall_freezes_s1, !adv && !rst, $stable(v1),
                    "stage one moved during stall")

endmodule
